>>> rtl/awb_otp_gain_calculator_macros.svh
`ifndef AWB_OTP_GAIN_CALCULATOR_MACROS_SVH
`define AWB_OTP_GAIN_CALCULATOR_MACROS_SVH

// check a consequence on every clock edge outside reset
`define AGC_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a consequence against a request taken a fixed number of cycles earlier
`define AGC_CHECK_PAST(lbl, ante, req, dly, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> $past(req, dly)) \
        else $error(msg);

`endif

>>> rtl/agc_pkg.sv
package agc_pkg;

    localparam int unsigned D1_STEPS = 24;
    localparam int unsigned D2_STEPS = 16;
    localparam int unsigned LATENCY  = D1_STEPS + D2_STEPS + 4;

    localparam logic [15:0] UNITY_GAIN     = 16'h0100;
    localparam logic [15:0] GAIN_MAX       = 16'hFFFF;
    localparam logic [15:0] RG_TYP_RESET   = 16'h030A;
    localparam logic [15:0] BG_TYP_RESET   = 16'h02E3;
    localparam logic [31:0] DIV_ZERO_QUOT  = 32'hFFFF_FFFF;

    localparam logic [1:0] CFG_RG_TYPICAL = 2'd0;
    localparam logic [1:0] CFG_BG_TYPICAL = 2'd1;

    typedef struct packed {
        logic        vld;
        logic        zero;
        logic [15:0] rg;
        logic [15:0] bg;
        logic [15:0] rem_r;
        logic [15:0] rem_b;
        logic [23:0] num_r;
        logic [23:0] num_b;
        logic [23:0] q_r;
        logic [23:0] q_b;
    } t_div1;

    typedef struct packed {
        logic        vld;
        logic        zero;
        logic [15:0] rg;
        logic [15:0] bg;
        logic [31:0] g;
        logic        do_r;
        logic        do_b;
    } t_sel;

    typedef struct packed {
        logic        vld;
        logic        zero;
        logic [15:0] rg;
        logic [15:0] bg;
        logic [31:0] g;
        logic        do_r;
        logic        do_b;
        logic [47:0] pr;
        logic [47:0] pb;
    } t_mul;

    typedef struct packed {
        logic        vld;
        logic        zero;
        logic [15:0] rg;
        logic [15:0] bg;
        logic [31:0] g;
        logic        do_r;
        logic        do_b;
        logic        sat_r;
        logic        sat_b;
        logic [15:0] rem_r;
        logic [15:0] rem_b;
        logic [15:0] num_r;
        logic [15:0] num_b;
        logic [15:0] q_r;
        logic [15:0] q_b;
    } t_div2;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [16:0] div_step(input logic [15:0] rem, input logic nb,
                                             input logic [15:0] den);
        logic [16:0] sh;
        logic [16:0] diff;
        sh   = {rem, nb};
        diff = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            return {1'b1, diff[15:0]};
        end
        return {1'b0, sh[15:0]};
    endfunction

endpackage

>>> rtl/awb_otp_gain_calculator.sv
// White-balance gain calculator. A request (rg_measured, bg_measured) is taken at
// every clock edge with start high and busy low, one per cycle; busy is high only in
// reset. Each result appears on the o_ ports, for one cycle marked by o_strobe, in
// request order; the receiver cannot hold it off. Each request passes through two
// bit-serial pipelined dividers: 24 stages for the green gain and 16 stages for
// the dependent red and blue gains, plus select, multiply, range check and output
// stages. Typical-ratio registers are written through the config
// channel, which is always ready, and must only change while no request is in flight.
module awb_otp_gain_calculator
    import agc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_rg_measured,
    input  logic [15:0] i_bg_measured,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic [15:0] o_red_gain,
    output logic [15:0] o_green_gain,
    output logic [15:0] o_blue_gain,
    output logic        o_red_apply,
    output logic        o_green_apply,
    output logic        o_blue_apply,
    output logic        o_result_valid,
    output logic        o_saturated
);

    logic        r_busy;
    logic [15:0] r_rg_typ;
    logic [15:0] r_bg_typ;

    t_div1 r_d1 [0:D1_STEPS];
    t_div1 n_d1 [0:D1_STEPS];
    t_sel  r_sel, n_sel;
    t_mul  r_mul, n_mul;
    t_div2 r_d2 [0:D2_STEPS];
    t_div2 n_d2 [0:D2_STEPS];

    logic        r_strobe, n_strobe;
    logic [15:0] r_red, n_red, r_green, n_green, r_blue, n_blue;
    logic        r_ra, n_ra, r_ga, n_ga, r_ba, n_ba, r_rv, n_rv, r_sat, n_sat;

    logic [31:0] gr, gb;
    logic        lt_r, lt_b;
    logic [16:0] st_r, st_b;
    logic [16:0] sr2, sb2;
    logic [15:0] fr, fg, fb;
    logic        sr, sg, sb;

    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_rg_typ <= RG_TYP_RESET;
            r_bg_typ <= BG_TYP_RESET;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_RG_TYPICAL: r_rg_typ <= i_cfg_data;
                    CFG_BG_TYPICAL: r_bg_typ <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_d1[0].vld   = start && !r_busy;
        n_d1[0].zero  = (i_rg_measured == 16'd0) || (i_bg_measured == 16'd0);
        n_d1[0].rg    = i_rg_measured;
        n_d1[0].bg    = i_bg_measured;
        n_d1[0].rem_r = 16'd0;
        n_d1[0].rem_b = 16'd0;
        n_d1[0].num_r = {i_rg_measured, 8'h00};
        n_d1[0].num_b = {i_bg_measured, 8'h00};
        n_d1[0].q_r   = 24'd0;
        n_d1[0].q_b   = 24'd0;
        for (int k = 0; k < D1_STEPS; k++) begin
            st_r          = div_step(r_d1[k].rem_r, r_d1[k].num_r[23], r_rg_typ);
            st_b          = div_step(r_d1[k].rem_b, r_d1[k].num_b[23], r_bg_typ);
            n_d1[k+1]       = r_d1[k];
            n_d1[k+1].rem_r = st_r[15:0];
            n_d1[k+1].rem_b = st_b[15:0];
            n_d1[k+1].num_r = {r_d1[k].num_r[22:0], 1'b0};
            n_d1[k+1].num_b = {r_d1[k].num_b[22:0], 1'b0};
            n_d1[k+1].q_r   = {r_d1[k].q_r[22:0], st_r[16]};
            n_d1[k+1].q_b   = {r_d1[k].q_b[22:0], st_b[16]};
        end
    end

    always_comb begin
        gr   = (r_rg_typ == 16'd0) ? DIV_ZERO_QUOT : {8'h00, r_d1[D1_STEPS].q_r};
        gb   = (r_bg_typ == 16'd0) ? DIV_ZERO_QUOT : {8'h00, r_d1[D1_STEPS].q_b};
        lt_r = r_d1[D1_STEPS].rg < r_rg_typ;
        lt_b = r_d1[D1_STEPS].bg < r_bg_typ;
        n_sel.vld  = r_d1[D1_STEPS].vld;
        n_sel.zero = r_d1[D1_STEPS].zero;
        n_sel.rg   = r_d1[D1_STEPS].rg;
        n_sel.bg   = r_d1[D1_STEPS].bg;
        priority if (lt_b && lt_r) begin
            n_sel.g = {16'd0, UNITY_GAIN}; n_sel.do_r = 1'b1; n_sel.do_b = 1'b1;
        end else if (lt_b) begin
            n_sel.g = gr; n_sel.do_r = 1'b0; n_sel.do_b = 1'b1;
        end else if (lt_r || (gb > gr)) begin
            n_sel.g = gb; n_sel.do_r = 1'b1; n_sel.do_b = 1'b0;
        end else begin
            n_sel.g = gr; n_sel.do_r = 1'b0; n_sel.do_b = 1'b1;
        end
    end

    always_comb begin
        n_mul.vld  = r_sel.vld;
        n_mul.zero = r_sel.zero;
        n_mul.rg   = r_sel.rg;
        n_mul.bg   = r_sel.bg;
        n_mul.g    = r_sel.g;
        n_mul.do_r = r_sel.do_r;
        n_mul.do_b = r_sel.do_b;
        n_mul.pr   = r_sel.g * r_rg_typ;
        n_mul.pb   = r_sel.g * r_bg_typ;
    end

    always_comb begin
        n_d2[0].vld   = r_mul.vld;
        n_d2[0].zero  = r_mul.zero;
        n_d2[0].rg    = r_mul.rg;
        n_d2[0].bg    = r_mul.bg;
        n_d2[0].g     = r_mul.g;
        n_d2[0].do_r  = r_mul.do_r;
        n_d2[0].do_b  = r_mul.do_b;
        n_d2[0].sat_r = r_mul.pr[47:16] >= {16'd0, r_mul.rg};
        n_d2[0].sat_b = r_mul.pb[47:16] >= {16'd0, r_mul.bg};
        n_d2[0].rem_r = r_mul.pr[31:16];
        n_d2[0].rem_b = r_mul.pb[31:16];
        n_d2[0].num_r = r_mul.pr[15:0];
        n_d2[0].num_b = r_mul.pb[15:0];
        n_d2[0].q_r   = 16'd0;
        n_d2[0].q_b   = 16'd0;
        for (int k = 0; k < D2_STEPS; k++) begin
            sr2           = div_step(r_d2[k].rem_r, r_d2[k].num_r[15], r_d2[k].rg);
            sb2           = div_step(r_d2[k].rem_b, r_d2[k].num_b[15], r_d2[k].bg);
            n_d2[k+1]       = r_d2[k];
            n_d2[k+1].rem_r = sr2[15:0];
            n_d2[k+1].rem_b = sb2[15:0];
            n_d2[k+1].num_r = {r_d2[k].num_r[14:0], 1'b0};
            n_d2[k+1].num_b = {r_d2[k].num_b[14:0], 1'b0};
            n_d2[k+1].q_r   = {r_d2[k].q_r[14:0], sr2[16]};
            n_d2[k+1].q_b   = {r_d2[k].q_b[14:0], sb2[16]};
        end
    end

    always_comb begin
        sr = r_d2[D2_STEPS].do_r && r_d2[D2_STEPS].sat_r;
        sb = r_d2[D2_STEPS].do_b && r_d2[D2_STEPS].sat_b;
        sg = r_d2[D2_STEPS].g[31:16] != 16'd0;
        fr = !r_d2[D2_STEPS].do_r ? UNITY_GAIN : (sr ? GAIN_MAX : r_d2[D2_STEPS].q_r);
        fb = !r_d2[D2_STEPS].do_b ? UNITY_GAIN : (sb ? GAIN_MAX : r_d2[D2_STEPS].q_b);
        fg = sg ? GAIN_MAX : r_d2[D2_STEPS].g[15:0];
        n_strobe = r_d2[D2_STEPS].vld;
        if (r_d2[D2_STEPS].zero) begin
            n_red = 16'd0; n_green = 16'd0; n_blue = 16'd0;
            n_ra = 1'b0; n_ga = 1'b0; n_ba = 1'b0; n_rv = 1'b0; n_sat = 1'b0;
        end else begin
            n_red = fr; n_green = fg; n_blue = fb;
            n_ra  = fr > UNITY_GAIN;
            n_ga  = fg > UNITY_GAIN;
            n_ba  = fb > UNITY_GAIN;
            n_rv  = 1'b1;
            n_sat = sr || sg || sb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_ra    <= n_ra;
        r_ga    <= n_ga;
        r_ba    <= n_ba;
        r_rv    <= n_rv;
        r_sat   <= n_sat;
        if (!i_rst_n) begin
            for (int k = 0; k <= D1_STEPS; k++) begin
                r_d1[k].vld <= 1'b0;
            end
            r_sel.vld <= 1'b0;
            r_mul.vld <= 1'b0;
            for (int k = 0; k <= D2_STEPS; k++) begin
                r_d2[k].vld <= 1'b0;
            end
            r_strobe <= 1'b0;
        end else begin
            for (int k = 0; k <= D1_STEPS; k++) begin
                r_d1[k] <= n_d1[k];
            end
            r_sel <= n_sel;
            r_mul <= n_mul;
            for (int k = 0; k <= D2_STEPS; k++) begin
                r_d2[k] <= n_d2[k];
            end
            r_strobe <= n_strobe;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_red_gain     = r_red;
    assign o_green_gain   = r_green;
    assign o_blue_gain    = r_blue;
    assign o_red_apply    = r_ra;
    assign o_green_apply  = r_ga;
    assign o_blue_apply   = r_ba;
    assign o_result_valid = r_rv;
    assign o_saturated    = r_sat;

endmodule

>>> rtl/agc_checker.sv
`include "awb_otp_gain_calculator_macros.svh"

module agc_checker
    import agc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [15:0] o_red_gain,
    input logic [15:0] o_green_gain,
    input logic [15:0] o_blue_gain,
    input logic        o_red_apply,
    input logic        o_green_apply,
    input logic        o_blue_apply,
    input logic        o_result_valid,
    input logic        o_saturated
);

    `AGC_CHECK_PAST(a_strobe_req, o_strobe, start && !busy, LATENCY + 1, "result without request")
    `AGC_CHECK(a_invalid_zero, o_strobe && !o_result_valid, (o_red_gain == 16'd0) && (o_green_gain == 16'd0) && (o_blue_gain == 16'd0) && !o_saturated && !o_red_apply && !o_green_apply && !o_blue_apply, "invalid result not cleared")
    `AGC_CHECK(a_sat_max, o_strobe && o_saturated, (o_red_gain == GAIN_MAX) || (o_green_gain == GAIN_MAX) || (o_blue_gain == GAIN_MAX), "saturated without clamped gain")
    `AGC_CHECK(a_apply, o_strobe && o_result_valid, (o_red_apply == (o_red_gain > UNITY_GAIN)) && (o_green_apply == (o_green_gain > UNITY_GAIN)) && (o_blue_apply == (o_blue_gain > UNITY_GAIN)), "apply bit mismatch")
    `AGC_CHECK(a_unity, o_strobe && o_result_valid, (o_red_gain == UNITY_GAIN) || (o_green_gain == UNITY_GAIN) || (o_blue_gain == UNITY_GAIN), "no channel held at unity")

endmodule

bind awb_otp_gain_calculator agc_checker u_agc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_red_gain     (o_red_gain),
    .o_green_gain   (o_green_gain),
    .o_blue_gain    (o_blue_gain),
    .o_red_apply    (o_red_apply),
    .o_green_apply  (o_green_apply),
    .o_blue_apply   (o_blue_apply),
    .o_result_valid (o_result_valid),
    .o_saturated    (o_saturated)
);

>>> tb/awb_otp_gain_calculator_tb.sv
`timescale 1ns / 1ps

module awb_otp_gain_calculator_tb;
    import agc_pkg::*;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        red_apply;
        logic        green_apply;
        logic        blue_apply;
        logic        ok;
        logic        sat;
    } t_gains;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_rg_measured = '0;
    logic [15:0] i_bg_measured = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_strobe;
    logic [15:0] o_red_gain;
    logic [15:0] o_green_gain;
    logic [15:0] o_blue_gain;
    logic        o_red_apply;
    logic        o_green_apply;
    logic        o_blue_apply;
    logic        o_result_valid;
    logic        o_saturated;

    awb_otp_gain_calculator dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [15:0] rg_typ = RG_TYP_RESET;
    logic [15:0] bg_typ = BG_TYP_RESET;
    t_gains      expected_gains[$];
    int          n_errors = 0;
    int          n_results = 0;
    int          n_requests = 0;
    int          n_saturated = 0;
    int          send_idle_pct = 0;

    function automatic logic [63:0] trunc_div(logic [63:0] num, logic [63:0] den);
        if (den == 0) begin
            return 64'hFFFF_FFFF;
        end
        return num / den;
    endfunction

    function automatic logic [15:0] clamp16(logic [63:0] g, inout logic sat);
        if (g > 64'hFFFF) begin
            sat = 1'b1;
            return 16'hFFFF;
        end
        return g[15:0];
    endfunction

    function automatic t_gains compute_gains(logic [15:0] rg, logic [15:0] bg);
        t_gains      res;
        logic [63:0] r, g, b, gb, gr, u;
        logic        sat;
        res = '0;
        sat = 1'b0;
        u = 64'(UNITY_GAIN);
        if (rg == 0 || bg == 0) begin
            return res;
        end
        if (bg < bg_typ) begin
            if (rg < rg_typ) begin
                g = u;
                b = trunc_div(u * bg_typ, bg);
                r = trunc_div(u * rg_typ, rg);
            end else begin
                r = u;
                g = trunc_div(u * rg, rg_typ);
                b = trunc_div(g * bg_typ, bg);
            end
        end else if (rg < rg_typ) begin
            b = u;
            g = trunc_div(u * bg, bg_typ);
            r = trunc_div(g * rg_typ, rg);
        end else begin
            gb = trunc_div(u * bg, bg_typ);
            gr = trunc_div(u * rg, rg_typ);
            if (gb > gr) begin
                b = u;
                g = gb;
                r = trunc_div(g * rg_typ, rg);
            end else begin
                r = u;
                g = gr;
                b = trunc_div(g * bg_typ, bg);
            end
        end
        res.red   = clamp16(r, sat);
        res.green = clamp16(g, sat);
        res.blue  = clamp16(b, sat);
        res.red_apply   = res.red > UNITY_GAIN;
        res.green_apply = res.green > UNITY_GAIN;
        res.blue_apply  = res.blue > UNITY_GAIN;
        res.ok  = 1'b1;
        res.sat = sat;
        return res;
    endfunction

    task automatic send_ratios(logic [15:0] rg, logic [15:0] bg);
        if (send_idle_pct > 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        start         <= 1'b1;
        i_rg_measured <= rg;
        i_bg_measured <= bg;
        do @(posedge i_clk); while (busy);
        expected_gains.push_back(compute_gains(rg, bg));
        n_requests++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_gains.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_typical(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_RG_TYPICAL) begin
            rg_typ = val;
        end else if (idx == CFG_BG_TYPICAL) begin
            bg_typ = val;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_ratios(int n);
        logic [15:0] rg, bg;
        repeat (n) begin
            case ($urandom_range(5))
                0: begin
                    rg = 16'($urandom);
                    bg = 16'($urandom);
                end
                1: begin
                    rg = 16'(rg_typ + $urandom_range(64) - 32);
                    bg = 16'(bg_typ + $urandom_range(64) - 32);
                end
                2: begin
                    rg = 16'($urandom_range(1, 16));
                    bg = 16'($urandom);
                end
                3: begin
                    rg = 16'($urandom);
                    bg = 16'($urandom_range(1, 16));
                end
                4: begin
                    rg = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
                    bg = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom);
                end
                default: begin
                    rg = 16'($urandom_range(1, 2 * rg_typ + 1));
                    bg = 16'($urandom_range(1, 2 * bg_typ + 1));
                end
            endcase
            send_ratios(rg, bg);
        end
    endtask

    task automatic test_directed_reset_typicals();
        send_ratios(16'd0, 16'd0);
        send_ratios(16'd0, 16'd500);
        send_ratios(16'd500, 16'd0);
        send_ratios(16'd1, 16'd1);
        send_ratios(16'hFFFF, 16'hFFFF);
        send_ratios(16'd700, 16'd700);
        send_ratios(16'd800, 16'd700);
        send_ratios(16'd700, 16'd800);
        send_ratios(16'd900, 16'd800);
        send_ratios(16'd800, 16'd900);
        send_ratios(RG_TYP_RESET, BG_TYP_RESET);
        send_ratios(16'd1, 16'hFFFF);
        send_ratios(16'hFFFF, 16'd1);
        send_ratios(16'h5555, 16'hAAAA);
        send_ratios(16'hAAAA, 16'h5555);
        drain();
    endtask

    task automatic test_extreme_typicals();
        write_typical(CFG_RG_TYPICAL, 16'hFFFF);
        write_typical(CFG_BG_TYPICAL, 16'd1);
        write_typical(2'd2, 16'h1234);
        write_typical(2'd3, 16'h4321);
        send_ratios(16'hFFFF, 16'd1);
        send_ratios(16'd1, 16'hFFFF);
        send_ratios(16'h8000, 16'd2);
        random_ratios(40);
        drain();
        write_typical(CFG_RG_TYPICAL, 16'd0);
        write_typical(CFG_BG_TYPICAL, 16'd0);
        send_ratios(16'd5, 16'd5);
        send_ratios(16'hFFFF, 16'hFFFF);
        random_ratios(20);
        drain();
    endtask

    task automatic test_random_phases();
        int pcts[4] = '{0, 76, 0, 32};
        foreach (pcts[p]) begin
            send_idle_pct = pcts[p];
            write_typical(CFG_RG_TYPICAL, 16'($urandom_range(1, 65535)));
            write_typical(CFG_BG_TYPICAL, ($urandom_range(1) == 0) ? 16'($urandom_range(1, 2000))
                                                                  : 16'($urandom_range(1, 65535)));
            random_ratios(100);
            drain();
            write_typical(CFG_RG_TYPICAL, 16'($urandom_range(1, 2000)));
            write_typical(CFG_BG_TYPICAL, 16'($urandom_range(1, 2000)));
            random_ratios(90);
            drain();
        end
        send_idle_pct = 0;
    endtask

    always @(posedge i_clk) begin
        t_gains exp_g;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (expected_gains.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                exp_g = expected_gains.pop_front();
                if (o_saturated) n_saturated++;
                if (o_red_gain !== exp_g.red) begin
                    $error("red_gain exp %h got %h", exp_g.red, o_red_gain);
                    n_errors++;
                end
                if (o_green_gain !== exp_g.green) begin
                    $error("green_gain exp %h got %h", exp_g.green, o_green_gain);
                    n_errors++;
                end
                if (o_blue_gain !== exp_g.blue) begin
                    $error("blue_gain exp %h got %h", exp_g.blue, o_blue_gain);
                    n_errors++;
                end
                if (o_red_apply !== exp_g.red_apply) begin
                    $error("red_apply exp %b got %b", exp_g.red_apply, o_red_apply);
                    n_errors++;
                end
                if (o_green_apply !== exp_g.green_apply) begin
                    $error("green_apply exp %b got %b", exp_g.green_apply, o_green_apply);
                    n_errors++;
                end
                if (o_blue_apply !== exp_g.blue_apply) begin
                    $error("blue_apply exp %b got %b", exp_g.blue_apply, o_blue_apply);
                    n_errors++;
                end
                if (o_result_valid !== exp_g.ok) begin
                    $error("result_valid exp %b got %b", exp_g.ok, o_result_valid);
                    n_errors++;
                end
                if (o_saturated !== exp_g.sat) begin
                    $error("saturated exp %b got %b", exp_g.sat, o_saturated);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_reset_typicals();
        test_extreme_typicals();
        test_random_phases();
        if (expected_gains.size() != 0) begin
            $error("%0d results never arrived", expected_gains.size());
            n_errors++;
        end
        $display("%0d requests sent, %0d results checked (%0d saturated)",
                 n_requests, n_results, n_saturated);
        $display("covered zero ratios, all four branches, extreme and zero typical ratios");
        if (n_errors == 0) begin
            $display("** awb_otp_gain_calculator: PASSED **");
        end else begin
            $display("** awb_otp_gain_calculator: FAILED **");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("** awb_otp_gain_calculator: FAILED **");
        $finish;
    end

endmodule
